FILE: hdl/pdc_pkg.sv
// pdc_pkg: shared constants for the dual-mode PID controller.
// Widths, register map codes and output limits. No dependencies.

package pdc_pkg;

	// field widths
	localparam int ErrW   = 16;
	localparam int GainW  = 16;
	localparam int LimitW = 20;
	localparam int SumW   = 21;
	localparam int DiffW  = 17;
	localparam int DriveW = 32;
	localparam int WideW  = 40;

	// configuration port
	localparam int AddrW = 5;
	localparam int DataW = 32;

	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_KP    = 3'd1,
		REG_KI    = 3'd2,
		REG_KD    = 3'd3,
		REG_LIMIT = 3'd4
	} reg_idx_t;

	// control modes
	localparam logic MODE_INCR = 1'b0;
	localparam logic MODE_POS  = 1'b1;

	// incremental clamp, +/-10000.0 in Q23.8
	localparam logic signed [WideW-1:0] DRIVE_CLAMP_HI = 40'sd2560000;
	localparam logic signed [WideW-1:0] DRIVE_CLAMP_LO = -40'sd2560000;

	// signed 32-bit saturation limits
	localparam logic signed [WideW-1:0] S32_HI = 40'sd2147483647;
	localparam logic signed [WideW-1:0] S32_LO = -40'sd2147483648;

endpackage

FILE: hdl/pid_controller_dual_mode_top.sv
// pid_controller_dual_mode_top: dual-mode (incremental / positional) PID.
// Depends on pdc_pkg for widths, register codes and limits.
//
// Usage:
//   Input channel  : error_value with in_valid / in_ready, one signed error
//                    sample per transaction.
//   Output channel : drive_value with out_valid / out_ready, one signed
//                    Q23.8 drive value per input transaction, in order.
//   APB-style port : control_mode at 0x00, prop_gain 0x04, integ_gain 0x08,
//                    deriv_gain 0x0C, integ_limit 0x10. The user must write
//                    them only while the controller is idle; the block does
//                    not enforce this. pready is always high.
// Datapath: input register, then one pass of the three gain multipliers,
//   adder and limiter into the result register. Throughput: one sample
//   per cycle unless the output stalls; the state update (previous error,
//   difference, error sum, running output) closes in that single pass.
// Reset: arst_n clears the config registers, controller state and both valid
//   flags. When out_ready is low the result register holds its value and
//   the input register fills; in_ready then drops until the result is taken.

module pid_controller_dual_mode_top
	import pdc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [AddrW-1:0]         paddr,
	input  logic [DataW-1:0]         pwdata,
	output logic [DataW-1:0]         prdata,
	output logic                     pready,
	// error samples
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ErrW-1:0]   error_value,
	// drive values
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DriveW-1:0] drive_value
);

	// configuration registers
	logic                     control_mode_q;
	logic signed [GainW-1:0]  prop_gain_q;
	logic signed [GainW-1:0]  integ_gain_q;
	logic signed [GainW-1:0]  deriv_gain_q;
	logic [LimitW-1:0]        integ_limit_q;

	// controller state
	logic signed [ErrW-1:0]   prev_error_q;
	logic signed [DiffW-1:0]  prev_diff_q;
	logic signed [SumW-1:0]   error_sum_q;
	logic signed [DriveW-1:0] drive_accum_q;

	// pipeline
	logic                     valid_s1;
	logic signed [ErrW-1:0]   error_s1;
	logic                     out_valid_q;
	logic                     advance;
	logic                     cfg_wr;

	// datapath
	logic signed [DiffW-1:0]  diff;
	logic signed [DiffW:0]    diff2;
	logic signed [SumW:0]     sum_raw;
	logic signed [SumW:0]     lim_pos;
	logic signed [SumW:0]     lim_neg;
	logic signed [SumW-1:0]   sum_next;
	logic signed [DiffW-1:0]  op_p;
	logic signed [SumW-1:0]   op_i;
	logic signed [DiffW:0]    op_d;
	logic signed [GainW+DiffW-1:0] prod_p;
	logic signed [GainW+SumW-1:0]  prod_i;
	logic signed [GainW+DiffW:0]   prod_d;
	logic signed [WideW-1:0]  terms;
	logic signed [WideW-1:0]  incr_sum;
	logic signed [WideW-1:0]  drive_wide;
	logic signed [DriveW-1:0] drive_next;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_mode_q <= MODE_INCR;
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			integ_limit_q  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[AddrW-1:2]))
				REG_MODE:  control_mode_q <= pwdata[0];
				REG_KP:    prop_gain_q    <= pwdata[GainW-1:0];
				REG_KI:    integ_gain_q   <= pwdata[GainW-1:0];
				REG_KD:    deriv_gain_q   <= pwdata[GainW-1:0];
				REG_LIMIT: integ_limit_q  <= pwdata[LimitW-1:0];
				default:   ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[AddrW-1:2]))
			REG_MODE:  prdata = {{(DataW-1){1'b0}}, control_mode_q};
			REG_KP:    prdata = {{(DataW-GainW){prop_gain_q[GainW-1]}}, prop_gain_q};
			REG_KI:    prdata = {{(DataW-GainW){integ_gain_q[GainW-1]}}, integ_gain_q};
			REG_KD:    prdata = {{(DataW-GainW){deriv_gain_q[GainW-1]}}, deriv_gain_q};
			REG_LIMIT: prdata = {{(DataW-LimitW){1'b0}}, integ_limit_q};
			default:   prdata = '0;
		endcase
	end

	// handshake: the input register moves on whenever the result slot is free
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			error_s1 <= error_value;
	end

	// differences
	assign diff  = DiffW'(error_s1) - DiffW'(prev_error_q);
	assign diff2 = (DiffW+1)'(diff) - (DiffW+1)'(prev_diff_q);

	// error sum limited to +/-integ_limit
	assign sum_raw = (SumW+1)'(error_sum_q) + (SumW+1)'(error_s1);
	assign lim_pos = (SumW+1)'(signed'({1'b0, integ_limit_q}));
	assign lim_neg = -lim_pos;

	always_comb begin
		if (sum_raw > lim_pos)
			sum_next = SumW'(lim_pos);
		else if (sum_raw < lim_neg)
			sum_next = SumW'(lim_neg);
		else
			sum_next = SumW'(sum_raw);
	end

	// multiplier operands shared between the two modes
	always_comb begin
		if (control_mode_q == MODE_POS) begin
			op_p = DiffW'(error_s1);
			op_i = sum_next;
			op_d = (DiffW+1)'(diff);
		end else begin
			op_p = diff;
			op_i = SumW'(error_s1);
			op_d = diff2;
		end
	end

	assign prod_p = (GainW+DiffW)'(prop_gain_q) * (GainW+DiffW)'(op_p);
	assign prod_i = (GainW+SumW)'(integ_gain_q) * (GainW+SumW)'(op_i);
	assign prod_d = (GainW+DiffW+1)'(deriv_gain_q) * (GainW+DiffW+1)'(op_d);

	assign terms    = WideW'(prod_p) + WideW'(prod_i) + WideW'(prod_d);
	assign incr_sum = WideW'(drive_accum_q) + terms;

	// output limiting per mode
	always_comb begin
		if (control_mode_q == MODE_POS) begin
			if (terms > S32_HI)
				drive_wide = S32_HI;
			else if (terms < S32_LO)
				drive_wide = S32_LO;
			else
				drive_wide = terms;
		end else begin
			if (incr_sum > DRIVE_CLAMP_HI)
				drive_wide = DRIVE_CLAMP_HI;
			else if (incr_sum < DRIVE_CLAMP_LO)
				drive_wide = DRIVE_CLAMP_LO;
			else
				drive_wide = incr_sum;
		end
	end

	assign drive_next = DriveW'(drive_wide);

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q  <= '0;
			prev_diff_q   <= '0;
			error_sum_q   <= '0;
			drive_accum_q <= '0;
		end else if (advance) begin
			prev_error_q  <= error_s1;
			drive_accum_q <= drive_next;
			if (control_mode_q == MODE_POS)
				error_sum_q <= sum_next;
			else
				prev_diff_q <= diff;
		end
	end

	assign drive_value = drive_accum_q;

	// checks
	a_incr_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		advance && control_mode_q == MODE_INCR |=>
		WideW'(drive_accum_q) <= DRIVE_CLAMP_HI && WideW'(drive_accum_q) >= DRIVE_CLAMP_LO)
		else $error("incremental output outside clamp");

	a_sum_limit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && control_mode_q == MODE_POS |=>
		(SumW+1)'(error_sum_q) <= lim_pos && (SumW+1)'(error_sum_q) >= lim_neg)
		else $error("error sum outside integrator limit");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(error_s1))
		else $error("pending sample lost from input register");

endmodule

FILE: bench/pid_controller_dual_mode_top_test.sv
`timescale 1ns / 1ps
// Testbench for the dual-mode PID controller: directed and random error samples,
// results checked against an in-bench model of both control modes.
// Depends on pdc_pkg and pid_controller_dual_mode_top.

module pid_controller_dual_mode_top_test;
	import pdc_pkg::*;

	localparam longint DriveClamp = 2560000;
	localparam longint Sat32Hi    = 2147483647;
	localparam longint Sat32Lo    = -Sat32Hi - 1;
	localparam int     CycleLimit = 500000;
	localparam int     PhaseCount = 12;
	localparam int     PhaseItems = 138;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     psel        = 1'b0;
	logic                     penable     = 1'b0;
	logic                     pwrite      = 1'b0;
	logic [AddrW-1:0]         paddr       = '0;
	logic [DataW-1:0]         pwdata      = '0;
	logic [DataW-1:0]         prdata;
	logic                     pready;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [ErrW-1:0]   error_value = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [DriveW-1:0] drive_value;

	// controller model: configuration and state
	logic                     cfg_mode  = MODE_INCR;
	logic signed [GainW-1:0]  cfg_kp    = '0;
	logic signed [GainW-1:0]  cfg_ki    = '0;
	logic signed [GainW-1:0]  cfg_kd    = '0;
	logic [LimitW-1:0]        cfg_limit = '0;
	logic signed [ErrW-1:0]   last_err  = '0;
	logic signed [DiffW-1:0]  last_diff = '0;
	logic signed [SumW-1:0]   err_sum   = '0;
	logic signed [DriveW-1:0] drive_acc = '0;

	logic signed [DriveW-1:0] drive_expected[$];

	int cycles        = 0;
	int failures      = 0;
	int items_sent    = 0;
	int drives_seen   = 0;
	int incr_steps    = 0;
	int pos_steps     = 0;
	int clamp_hits    = 0;
	int sat_hits      = 0;
	int burst_left    = 0;
	bit steady_sender = 1'b0;
	logic signed [ErrW-1:0] last_sent = '0;

	pid_controller_dual_mode_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.error_value(error_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_value(drive_value)
	);

	always #10 clk = ~clk;

	// cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles, %0d drive values outstanding",
				cycles, drive_expected.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver back-pressure: free, light, heavy and periodic stalls in turn
	always @(posedge clk) begin
		case ((cycles / 300) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((cycles % 7) < 3);
		endcase
	end

	// compare each drive transaction with the oldest prediction
	always @(posedge clk) begin
		logic signed [DriveW-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			drives_seen++;
			if (drive_expected.size() == 0) begin
				$error("drive_value: unexpected transaction, expected none, actual %0d",
					drive_value);
				failures++;
			end else begin
				want = drive_expected.pop_front();
				if (drive_value !== want) begin
					$error("drive_value mismatch: expected %0d, actual %0d", want,
						drive_value);
					failures++;
				end
			end
		end
	end

	// one controller step; updates the model state and returns the drive value
	function automatic logic signed [DriveW-1:0] predict_drive(input logic signed [ErrW-1:0] e);
		longint ev, diff, dd, acc, sum, lim, kp, ki, kd;
		ev   = longint'(e);
		kp   = longint'(cfg_kp);
		ki   = longint'(cfg_ki);
		kd   = longint'(cfg_kd);
		diff = ev - longint'(last_err);
		if (cfg_mode == MODE_INCR) begin
			dd  = diff - longint'(last_diff);
			acc = longint'(drive_acc) + kp * diff + ki * ev + kd * dd;
			if (acc > DriveClamp) begin
				acc = DriveClamp;
				clamp_hits++;
			end else if (acc < -DriveClamp) begin
				acc = -DriveClamp;
				clamp_hits++;
			end
			last_diff = DiffW'(diff);
			incr_steps++;
		end else begin
			lim = longint'(cfg_limit);
			sum = longint'(err_sum) + ev;
			if (sum > lim)
				sum = lim;
			else if (sum < -lim)
				sum = -lim;
			err_sum = SumW'(sum);
			acc = kp * ev + ki * sum + kd * diff;
			if (acc > Sat32Hi) begin
				acc = Sat32Hi;
				sat_hits++;
			end else if (acc < Sat32Lo) begin
				acc = Sat32Lo;
				sat_hits++;
			end
			pos_steps++;
		end
		last_err  = e;
		drive_acc = DriveW'(acc);
		return drive_acc;
	endfunction

	// register write: setup and access phases, then the bus returns to idle
	task automatic cfg_write(input int idx, input logic [DataW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MODE:  cfg_mode  = data[0];
			REG_KP:    cfg_kp    = data[GainW-1:0];
			REG_KI:    cfg_ki    = data[GainW-1:0];
			REG_KD:    cfg_kd    = data[GainW-1:0];
			REG_LIMIT: cfg_limit = data[LimitW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_gains(input logic signed [GainW-1:0] kp, ki, kd);
		cfg_write(REG_KP, DataW'(kp));
		cfg_write(REG_KI, DataW'(ki));
		cfg_write(REG_KD, DataW'(kd));
	endtask

	// send one error sample; bursts of random length with random gaps between, none when steady_sender is set
	task automatic send_error(input logic signed [ErrW-1:0] e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_sender ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		error_value <= e;
		do @(posedge clk); while (!in_ready);
		drive_expected.push_back(predict_drive(e));
		last_sent = e;
		items_sent++;
	endtask

	// stop sending and let every outstanding drive value come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (drive_expected.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic signed [GainW-1:0] pick_gain();
		int g;
		case ($urandom_range(0, 3))
			0: g = $urandom_range(0, 65535);
			1: g = $urandom_range(0, 1024) - 512;
			2: case ($urandom_range(0, 2))
				0: g = 32767;
				1: g = -32768;
				default: g = 0;
			endcase
			default: g = $urandom_range(0, 4096) - 2048;
		endcase
		return GainW'(g);
	endfunction

	function automatic logic [LimitW-1:0] pick_limit();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return LimitW'($urandom_range(1, 64));
			2: return '1;
			default: return LimitW'($urandom);
		endcase
	endfunction

	// smooth error trajectories, mixed with random values, small noise and extremes
	function automatic logic signed [ErrW-1:0] pick_error();
		int v;
		case ($urandom_range(0, 7))
			0, 1, 2: return ErrW'($urandom);
			3: v = $urandom_range(0, 128) - 64;
			4: case ($urandom_range(0, 4))
				0: v = 32767;
				1: v = -32768;
				2: v = -1;
				3: v = 1;
				default: v = 0;
			endcase
			5: v = int'(last_sent);
			default: begin
				v = int'(last_sent) + $urandom_range(0, 64) - 32;
				if (v > 32767)
					v = 32767;
				else if (v < -32768)
					v = -32768;
			end
		endcase
		return ErrW'(v);
	endfunction

	// registers at reset: incremental mode, zero gains, so all drives are zero
	task automatic test_reset_defaults();
		send_error(16'sd32767);
		send_error(-16'sd32768);
	endtask

	// incremental mode with extreme gains drives the running output into both clamps
	task automatic test_incremental_clamp();
		wait_drained();
		cfg_write(REG_MODE, DataW'(MODE_INCR));
		set_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_error(16'sd32767);
		send_error(-16'sd32768);
		send_error(16'sd0);
		send_error(16'sd1);
		send_error(-16'sd1);
		send_error(16'sd32767);
	endtask

	// positional mode with full gains and a wide limit saturates at both ends
	task automatic test_positional_saturation();
		wait_drained();
		cfg_write(REG_MODE, DataW'(MODE_POS));
		set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		cfg_write(REG_LIMIT, DataW'(20'hFFFFF));
		repeat (3) send_error(16'sd32767);
		repeat (4) send_error(-16'sd32768);
	endtask

	// zero limit pins the error sum at zero, so the integral term vanishes
	task automatic test_zero_limit();
		wait_drained();
		set_gains(16'sd0, 16'sh7FFF, 16'sd0);
		cfg_write(REG_LIMIT, '0);
		send_error(16'sd100);
		send_error(-16'sd200);
		send_error(16'sd5);
	endtask

	// switching modes: incremental starts from a saturated output; error sum and last diff are per mode
	task automatic test_mode_switch();
		wait_drained();
		set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		cfg_write(REG_LIMIT, DataW'(20'hFFFFF));
		send_error(16'sd32767);
		send_error(16'sd32767);
		wait_drained();
		cfg_write(REG_MODE, DataW'(MODE_INCR));
		set_gains(16'sd0, 16'sd0, 16'sd256);
		send_error(16'sd0);
		send_error(16'sd0);
		wait_drained();
		cfg_write(REG_MODE, DataW'(MODE_POS));
		send_error(16'sd3);
		wait_drained();
		cfg_write(REG_MODE, DataW'(MODE_INCR));
		send_error(-16'sd7);
	endtask

	// writes above the last register must leave the configuration alone
	task automatic test_unmapped_registers();
		wait_drained();
		for (int i = REG_LIMIT + 1; i < 2 ** $bits(reg_idx_t); i++)
			cfg_write(i, $urandom);
		send_error(16'sd1234);
		send_error(-16'sd4321);
	endtask

	// random configuration per phase, first two at the gain extremes
	task automatic test_random_phases();
		logic                    mode;
		logic signed [GainW-1:0] kp, ki, kd;
		logic [LimitW-1:0]       lim;
		for (int p = 0; p < PhaseCount; p++) begin
			wait_drained();
			mode = 1'($urandom_range(0, 1));
			case (p)
				0: begin
					kp  = 16'sh7FFF;
					ki  = 16'sh7FFF;
					kd  = 16'sh7FFF;
					lim = '1;
				end
				1: begin
					kp  = 16'sh8000;
					ki  = 16'sh8000;
					kd  = 16'sh8000;
					lim = '0;
				end
				default: begin
					kp  = pick_gain();
					ki  = pick_gain();
					kd  = pick_gain();
					lim = pick_limit();
				end
			endcase
			cfg_write(REG_MODE, DataW'(mode));
			set_gains(kp, ki, kd);
			cfg_write(REG_LIMIT, DataW'(lim));
			steady_sender = (p % 4 == 3);
			for (int n = 0; n < PhaseItems; n++)
				send_error(pick_error());
		end
		steady_sender = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_incremental_clamp();
		test_positional_saturation();
		test_zero_limit();
		test_mode_switch();
		test_unmapped_registers();
		test_random_phases();

		wait_drained();
		repeat (4) @(posedge clk);
		if (drive_expected.size() != 0) begin
			$error("drive_value: %0d expected transactions never arrived",
				drive_expected.size());
			failures++;
		end

		$display("Sent %0d error samples (%0d incremental, %0d positional) over %0d phases.",
			items_sent, incr_steps, pos_steps, PhaseCount);
		$display("Checked %0d drive values; output clamp hit %0d times, saturation %0d times.",
			drives_seen, clamp_hits, sat_hits);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
